FILE: sv/modular_field_alu_assert.svh
// Assertion macros shared by the modular field ALU modules.
// Each macro expands to a concurrent assertion, or to nothing under SYNTHESIS.
`ifndef MODULAR_FIELD_ALU_ASSERT_SVH
`define MODULAR_FIELD_ALU_ASSERT_SVH

`ifndef SYNTHESIS

`define MFA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modular_field_alu: same-cycle check failed");

`define MFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modular_field_alu: next-cycle check failed");

`else

`define MFA_ASSERT_SAME(label, clk, rst, ante, cons)
`define MFA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/mfa_pkg.sv
// Package for the modular field ALU: widths, command codes, register map,
// beat types and the request/response types of the shared divider. No dependencies.
`default_nettype none

package mfa_pkg;

   localparam int WIDTH  = 16;
   localparam int CW     = WIDTH + 2;      // signed Euclid coefficients
   localparam int PW     = 2 * WIDTH;      // product width
   localparam int CNT_W  = $clog2(PW + 1);
   localparam int ADDR_W = 3;

   localparam logic [WIDTH-1:0]  RESET_MODULUS = WIDTH'(23);
   localparam logic [ADDR_W-1:0] ADDR_MODULUS  = '0;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_INV = 3'd4;
   localparam logic [2:0] CMD_CMP = 3'd5;

   typedef struct packed {
      logic [2:0]       command;
      logic [WIDTH-1:0] operand_a;
      logic [WIDTH-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [WIDTH-1:0] result;
      logic             is_equal;
      logic             is_less;
      logic             is_greater;
      logic             no_inverse;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic             long_op;
      logic [PW-1:0]    dividend;
      logic [WIDTH-1:0] divisor;
      logic [CW-1:0]    coef;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [WIDTH-1:0] rem;
      logic [CW-1:0]    qc;
   } div_rsp_type;

endpackage

`default_nettype wire

FILE: sv/modular_field_alu.sv
// Top level of the modular field ALU: APB register, command sequencer, beat
// registers and the shared divider. Uses mfa_pkg and mfa_div_unit.
//
//   port group   direction  handshake                   beat
//   req_         in         start high while busy low   req_data (command, operands)
//   rsp_         out        rsp_strobe, one cycle       rsp_data (result, flags)
//   APB          in/out     psel, penable, pready       modulus at address 0
//
// Each operand is reduced by the shared divider before dispatch.
// Add, subtract and compare finish after both reductions; multiply adds a
// long division of the product. Inverse: one divider run per Euclid step, at
// most about 1.44*WIDTH steps; divide is inverse plus multiply.
// Reset is synchronous; busy stays high until the result beat; no stall exists.
`default_nettype none
`include "modular_field_alu_assert.svh"

module modular_field_alu (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  mfa_pkg::req_type               req_data,
   output logic                           rsp_strobe,
   output mfa_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mfa_pkg::ADDR_W-1:0]     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import mfa_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_RED_A     = 10'b00_0000_0010,
      ST_RED_B     = 10'b00_0000_0100,
      ST_DISPATCH  = 10'b00_0000_1000,
      ST_EUC_CHECK = 10'b00_0001_0000,
      ST_EUC_WAIT  = 10'b00_0010_0000,
      ST_EUC_FIX   = 10'b00_0100_0000,
      ST_MUL_GO    = 10'b00_1000_0000,
      ST_MUL_WAIT  = 10'b01_0000_0000,
      ST_FINISH    = 10'b10_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [WIDTH-1:0]        modulus_ff, modulus_in;
   logic [2:0]              cmd_ff, cmd_in;
   logic [WIDTH-1:0]        b_raw_ff, b_raw_in;
   logic [WIDTH-1:0]        a_red_ff, a_red_in;
   logic [WIDTH-1:0]        b_red_ff, b_red_in;
   logic [WIDTH-1:0]        op2_ff, op2_in;
   logic [WIDTH-1:0]        res_ff, res_in;
   logic                    noinv_ff, noinv_in;
   logic [WIDTH-1:0]        r_run_ff, r_run_in;
   logic [WIDTH-1:0]        r_oth_ff, r_oth_in;
   logic signed [CW-1:0]    c_run_ff, c_run_in;
   logic signed [CW-1:0]    c_oth_ff, c_oth_in;
   logic                    strobe_ff, strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   div_req_type             div_req;
   div_rsp_type             div_rsp;

   logic [WIDTH-1:0]        p;
   logic [WIDTH:0]          add_sum;
   logic [WIDTH:0]          sub_sum;
   logic [WIDTH-1:0]        add_res;
   logic [WIDTH-1:0]        sub_res;
   logic                    swap;
   logic [WIDTH-1:0]        nr_run;
   logic [WIDTH-1:0]        nr_oth;
   logic signed [CW-1:0]    nc_run;
   logic signed [CW-1:0]    nc_oth;
   logic signed [CW-1:0]    p_ext;
   logic signed [CW-1:0]    inv_wide;
   logic [WIDTH-1:0]        inv_val;
   logic [PW-1:0]           prod;
   logic                    csr_write;
   logic [2:0]              rsp_flags;

   mfa_div_unit u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign p = (modulus_ff == '0) ? WIDTH'(1) : modulus_ff;

   assign add_sum = {1'b0, a_red_ff} + {1'b0, b_red_ff};
   assign sub_sum = {1'b0, a_red_ff} + ({1'b0, p} - {1'b0, b_red_ff});
   assign add_res = (add_sum >= {1'b0, p}) ? WIDTH'(add_sum - {1'b0, p}) : add_sum[WIDTH-1:0];
   assign sub_res = (sub_sum >= {1'b0, p}) ? WIDTH'(sub_sum - {1'b0, p}) : sub_sum[WIDTH-1:0];

   assign swap   = (r_run_ff < r_oth_ff);
   assign nr_run = swap ? r_oth_ff : r_run_ff;
   assign nr_oth = swap ? r_run_ff : r_oth_ff;
   assign nc_run = swap ? c_oth_ff : c_run_ff;
   assign nc_oth = swap ? c_run_ff : c_oth_ff;

   assign p_ext = {2'b00, p};

   always_comb begin
      if (c_oth_ff[CW-1]) begin
         inv_wide = c_oth_ff + p_ext;
      end else if (c_oth_ff >= p_ext) begin
         inv_wide = c_oth_ff - p_ext;
      end else begin
         inv_wide = c_oth_ff;
      end
   end

   assign inv_val = inv_wide[WIDTH-1:0];
   assign prod    = a_red_ff * op2_ff;

   assign csr_write = psel && penable && pwrite && (paddr == ADDR_MODULUS);

   always_comb begin
      state_in   = state_ff;
      modulus_in = modulus_ff;
      cmd_in     = cmd_ff;
      b_raw_in   = b_raw_ff;
      a_red_in   = a_red_ff;
      b_red_in   = b_red_ff;
      op2_in     = op2_ff;
      res_in     = res_ff;
      noinv_in   = noinv_ff;
      r_run_in   = r_run_ff;
      r_oth_in   = r_oth_ff;
      c_run_in   = c_run_ff;
      c_oth_in   = c_oth_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      div_req    = '0;

      if (csr_write) begin
         modulus_in = pwdata[WIDTH-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in           = req_data.command;
               b_raw_in         = req_data.operand_b;
               res_in           = '0;
               noinv_in         = 1'b0;
               div_req.start    = 1'b1;
               div_req.dividend = PW'(req_data.operand_a);
               div_req.divisor  = p;
               state_in         = ST_RED_A;
            end
         end
         ST_RED_A: begin
            if (div_rsp.done) begin
               a_red_in         = div_rsp.rem;
               div_req.start    = 1'b1;
               div_req.dividend = PW'(b_raw_ff);
               div_req.divisor  = p;
               state_in         = ST_RED_B;
            end
         end
         ST_RED_B: begin
            if (div_rsp.done) begin
               b_red_in = div_rsp.rem;
               op2_in   = div_rsp.rem;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (cmd_ff)
               CMD_ADD: begin
                  res_in   = add_res;
                  state_in = ST_FINISH;
               end
               CMD_SUB: begin
                  res_in   = sub_res;
                  state_in = ST_FINISH;
               end
               CMD_MUL: begin
                  state_in = ST_MUL_GO;
               end
               CMD_DIV: begin
                  if (b_red_ff == '0) begin
                     noinv_in = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     r_run_in = b_red_ff;
                     c_run_in = CW'(1);
                     r_oth_in = p;
                     c_oth_in = '0;
                     state_in = ST_EUC_CHECK;
                  end
               end
               CMD_INV: begin
                  if (a_red_ff == '0) begin
                     noinv_in = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     r_run_in = a_red_ff;
                     c_run_in = CW'(1);
                     r_oth_in = p;
                     c_oth_in = '0;
                     state_in = ST_EUC_CHECK;
                  end
               end
               CMD_CMP: begin
                  state_in = ST_FINISH;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_EUC_CHECK: begin
            if (r_run_ff == '0) begin
               state_in = ST_EUC_FIX;
            end else begin
               // swap so the running remainder is the larger, then divide
               r_run_in         = nr_run;
               r_oth_in         = nr_oth;
               c_run_in         = nc_run;
               c_oth_in         = nc_oth;
               div_req.start    = 1'b1;
               div_req.dividend = PW'(nr_run);
               div_req.divisor  = nr_oth;
               div_req.coef     = nc_oth;
               state_in         = ST_EUC_WAIT;
            end
         end
         ST_EUC_WAIT: begin
            if (div_rsp.done) begin
               r_run_in = div_rsp.rem;
               c_run_in = c_run_ff - $signed(div_rsp.qc);
               state_in = ST_EUC_CHECK;
            end
         end
         ST_EUC_FIX: begin
            if (cmd_ff == CMD_INV) begin
               res_in   = inv_val;
               state_in = ST_FINISH;
            end else begin
               op2_in   = inv_val;
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            div_req.start    = 1'b1;
            div_req.long_op  = 1'b1;
            div_req.dividend = prod;
            div_req.divisor  = p;
            state_in         = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (div_rsp.done) begin
               res_in   = div_rsp.rem;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            strobe_in         = 1'b1;
            rsp_in.result     = res_ff;
            rsp_in.is_equal   = (a_red_ff == b_red_ff);
            rsp_in.is_less    = (a_red_ff < b_red_ff);
            rsp_in.is_greater = (a_red_ff > b_red_ff);
            rsp_in.no_inverse = noinv_ff;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         strobe_ff  <= 1'b0;
         modulus_ff <= RESET_MODULUS;
      end else begin
         state_ff   <= state_in;
         strobe_ff  <= strobe_in;
         modulus_ff <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      b_raw_ff <= b_raw_in;
      a_red_ff <= a_red_in;
      b_red_ff <= b_red_in;
      op2_ff   <= op2_in;
      res_ff   <= res_in;
      noinv_ff <= noinv_in;
      r_run_ff <= r_run_in;
      r_oth_ff <= r_oth_in;
      c_run_ff <= c_run_in;
      c_oth_ff <= c_oth_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
   assign prdata     = (paddr == ADDR_MODULUS) ? 32'(modulus_ff) : '0;
   assign pready     = 1'b1;

   assign rsp_flags = {rsp_ff.is_equal, rsp_ff.is_less, rsp_ff.is_greater};

   `MFA_ASSERT_SAME(a_rsp_when_idle, clock, reset, strobe_ff, !busy)
   `MFA_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy)
   `MFA_ASSERT_SAME(a_flags_onehot, clock, reset, strobe_ff, $onehot(rsp_flags))
   `MFA_ASSERT_SAME(a_noinv_zero, clock, reset, strobe_ff && rsp_ff.no_inverse, rsp_ff.result == '0)

endmodule

`default_nettype wire

FILE: sv/mfa_div_unit.sv
// Shared shift-subtract divider: one quotient bit per cycle, remainder plus
// a running quotient-times-coefficient sum for the Euclid update. Uses mfa_pkg.
`default_nettype none
`include "modular_field_alu_assert.svh"

module mfa_div_unit (
   input  logic                clock,
   input  logic                reset,
   input  mfa_pkg::div_req_type div_req,
   output mfa_pkg::div_rsp_type div_rsp
);
   import mfa_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]    dvd_ff, dvd_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [CW-1:0]    coef_ff, coef_in;
   logic [CW-1:0]    acc_ff, acc_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             ge;

   assign trial = {rem_ff, dvd_ff[PW-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = (trial >= {1'b0, d_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      coef_in = coef_ff;
      acc_in  = acc_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         acc_in  = '0;
         d_in    = div_req.divisor;
         coef_in = div_req.coef;
         if (div_req.long_op) begin
            dvd_in = div_req.dividend;
            cnt_in = CNT_W'(PW);
         end else begin
            dvd_in = {div_req.dividend[WIDTH-1:0], {WIDTH{1'b0}}};
            cnt_in = CNT_W'(WIDTH);
         end
      end else if (busy_ff) begin
         // advance one quotient bit
         rem_in = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         dvd_in = {dvd_ff[PW-2:0], 1'b0};
         acc_in = {acc_ff[CW-2:0], 1'b0} + (ge ? coef_ff : '0);
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      d_ff    <= d_in;
      coef_ff <= coef_in;
      acc_ff  <= acc_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;
   assign div_rsp.qc   = acc_ff;

   `MFA_ASSERT_SAME(a_div_start_idle, clock, reset, div_req.start, !busy_ff)
   `MFA_ASSERT_SAME(a_div_done_idle, clock, reset, done_ff, !busy_ff)
   `MFA_ASSERT_SAME(a_div_rem_below, clock, reset, done_ff && (d_ff != '0), rem_ff < d_ff)

endmodule

`default_nettype wire
